/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the FFT core.
// No dependencies; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check under reset
`define CHK_IMPL(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("check failed");

// Next-cycle implication check under reset
`define CHK_NEXT(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("check failed");

`endif

/* hw/rtl/fftr2_pkg.sv */
// Package for the radix-2 FFT core: sizes, types, twiddle table, helpers.
// No dependencies.
package fftr2_pkg;

    localparam int STAGES = 6;
    localparam int POINTS = 1 << STAGES;
    localparam int AW = STAGES;
    localparam int SW = $clog2(STAGES + 1);
    localparam int CW = 24;
    localparam int DW = 2 * CW;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RD_A,
        ST_RD_B,
        ST_MUL,
        ST_WR,
        ST_EMIT
    } state_t;

    // Butterfly control from sequencer to datapath
    typedef struct packed {
        logic          mul_en;
        logic          wr_en;
        logic [AW-1:0] tw_k;
    } bfly_ctrl_t;

    // cos(2*pi*k/64), Q1.15, k = 0..16
    function automatic logic signed [16:0] qcos(input logic [4:0] k);
        logic signed [16:0] v;
        case (k)
            5'd0: v = 17'sd32767;
            5'd1: v = 17'sd32610;
            5'd2: v = 17'sd32138;
            5'd3: v = 17'sd31357;
            5'd4: v = 17'sd30274;
            5'd5: v = 17'sd28899;
            5'd6: v = 17'sd27246;
            5'd7: v = 17'sd25330;
            5'd8: v = 17'sd23170;
            5'd9: v = 17'sd20788;
            5'd10: v = 17'sd18205;
            5'd11: v = 17'sd15447;
            5'd12: v = 17'sd12540;
            5'd13: v = 17'sd9512;
            5'd14: v = 17'sd6393;
            5'd15: v = 17'sd3212;
            default: v = 17'sd0;
        endcase
        return v;
    endfunction

    // cos of a 64-point twiddle index (only k < 32 is used)
    function automatic logic signed [16:0] cos64(input logic [AW-1:0] k);
        logic [4:0] m;
        m = k[4:0];
        if (m <= 5'd16)
            return qcos(m);
        return -qcos(5'(6'd32 - {1'b0, m}));
    endfunction

    function automatic logic signed [16:0] sin64(input logic [AW-1:0] k);
        logic [4:0] m;
        m = k[4:0];
        if (m <= 5'd16)
            return qcos(5'(5'd16 - m));
        return qcos(5'(m - 5'd16));
    endfunction

    function automatic logic [AW-1:0] bit_rev(input logic [AW-1:0] v);
        logic [AW-1:0] r;
        for (int i = 0; i < AW; i++)
            r[i] = v[AW-1-i];
        return r;
    endfunction

    function automatic logic signed [CW-1:0] sat24(input logic signed [CW+1:0] v);
        if (v > 26'sd8388607)
            return 24'sh7FFFFF;
        if (v < -26'sd8388608)
            return 24'sh800000;
        return v[CW-1:0];
    endfunction

    // Round half up by 2^STAGES and saturate to 16 bits
    function automatic logic signed [15:0] scale_out(input logic signed [CW-1:0] v);
        logic signed [CW:0] r;
        r = ($signed({v[CW-1], v}) + (25'sd1 <<< (STAGES - 1))) >>> STAGES;
        if (r > 25'sd32767)
            return 16'sh7FFF;
        if (r < -25'sd32768)
            return 16'sh8000;
        return r[15:0];
    endfunction

endpackage

/* hw/rtl/fftr2_bfly.sv */
// Shared butterfly unit: complex twiddle multiply, then sum and difference.
// Depends on fftr2_pkg.
module fftr2_bfly (
    input  logic                       clk,
    input  fftr2_pkg::bfly_ctrl_t      ctrl,
    input  logic [fftr2_pkg::DW-1:0]   a_word,
    input  logic [fftr2_pkg::DW-1:0]   b_word,
    output logic [fftr2_pkg::DW-1:0]   sum_word,
    output logic [fftr2_pkg::DW-1:0]   dif_word
);
    logic signed [16:0] c_w, d_w;
    logic signed [23:0] br, bi;
    logic signed [41:0] p_cr_reg, p_di_reg, p_dr_reg, p_ci_reg;
    logic signed [42:0] tr_full, ti_full;
    logic signed [25:0] tr, ti;
    logic signed [23:0] ar, ai;

    assign c_w = fftr2_pkg::cos64(ctrl.tw_k);
    assign d_w = -fftr2_pkg::sin64(ctrl.tw_k);
    assign br  = b_word[47:24];
    assign bi  = b_word[23:0];

    // Four registered partial products
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            p_cr_reg <= 42'(c_w * br);
            p_di_reg <= 42'(d_w * bi);
            p_dr_reg <= 42'(d_w * br);
            p_ci_reg <= 42'(c_w * bi);
        end
    end

    // Round half up by 2^15; twiddled term may exceed 24 bits
    assign tr_full = (43'(p_cr_reg) - 43'(p_di_reg) + 43'sd16384) >>> 15;
    assign ti_full = (43'(p_dr_reg) + 43'(p_ci_reg) + 43'sd16384) >>> 15;
    assign tr = tr_full[25:0];
    assign ti = ti_full[25:0];
    assign ar = a_word[47:24];
    assign ai = a_word[23:0];

    assign sum_word = {fftr2_pkg::sat24(26'(ar) + tr), fftr2_pkg::sat24(26'(ai) + ti)};
    assign dif_word = {fftr2_pkg::sat24(26'(ar) - tr), fftr2_pkg::sat24(26'(ai) - ti)};
endmodule

/* hw/rtl/fft_radix2_forward_1d_core.sv */
// Top level of the radix-2 forward FFT core: sequencer, two stores, output.
// Depends on fftr2_pkg, fftr2_bfly and assert_macros.svh.
//
// Usage: one real sample per request on sample, taken when start is high
// and busy is low. Samples are stored at bit-reversed addresses. After the
// 64th sample busy rises and the core runs 6 decimation-in-time stages, one
// butterfly at a time through a single shared butterfly unit (read A, read
// B, multiply, write sum, write difference). It then emits 64 bins in order,
// one per cycle, with done high for each bin; final_bin marks the last. Busy
// stays high from the last sample until the cycle that shows the last bin.
// The single read and write port of each store set the pace. The receiver
// cannot stall: each bin is shown for exactly one cycle. Reset clears the
// sequencer and sample count; store contents are not reset.
`include "assert_macros.svh"
module fft_radix2_forward_1d_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] sample,
    output logic               done,
    output logic signed [15:0] bin_real,
    output logic signed [15:0] bin_imag,
    output logic               final_bin
);
    localparam int AW = fftr2_pkg::AW;
    localparam int DW = fftr2_pkg::DW;

    fftr2_pkg::state_t state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [fftr2_pkg::SW-1:0] stg_reg, stg_next;
    logic          src_ping_reg, src_ping_next;
    logic          accept;

    logic [DW-1:0] ping_mem [fftr2_pkg::POINTS];
    logic [DW-1:0] pong_mem [fftr2_pkg::POINTS];
    logic [DW-1:0] rd_reg, a_reg;
    logic [AW-1:0] rd_addr, ia, ib, half_mask;
    logic [DW-1:0] sum_word, dif_word;
    logic          wr_second_reg;
    fftr2_pkg::bfly_ctrl_t ctrl;
    logic          emit_vld_reg, emit_last_reg;

    assign accept = start && !busy;

    // Pair addressing: insert a zero at bit stg into the counter
    always_comb
    begin
        half_mask = AW'((1 << stg_reg) - 1);
        ia = ((cnt_reg & ~half_mask) << 1) | (cnt_reg & half_mask);
        ib = ia | AW'(1 << stg_reg);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        stg_next = stg_reg;
        src_ping_next = src_ping_reg;
        case (state_reg)
            fftr2_pkg::ST_LOAD:
            begin
                if (accept)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == AW'(fftr2_pkg::POINTS - 1))
                    begin
                        state_next = fftr2_pkg::ST_RD_A;
                        stg_next = '0;
                        src_ping_next = 1'b0;
                    end
                end
            end
            fftr2_pkg::ST_RD_A: state_next = fftr2_pkg::ST_RD_B;
            fftr2_pkg::ST_RD_B: state_next = fftr2_pkg::ST_MUL;
            fftr2_pkg::ST_MUL:  state_next = fftr2_pkg::ST_WR;
            fftr2_pkg::ST_WR:
            begin
                if (wr_second_reg)
                begin
                    state_next = fftr2_pkg::ST_RD_A;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == AW'(fftr2_pkg::POINTS / 2 - 1))
                    begin
                        cnt_next = '0;
                        src_ping_next = !src_ping_reg;
                        if (stg_reg == fftr2_pkg::SW'(fftr2_pkg::STAGES - 1))
                            state_next = fftr2_pkg::ST_EMIT;
                        else
                            stg_next = stg_reg + 1'b1;
                    end
                end
            end
            fftr2_pkg::ST_EMIT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == AW'(fftr2_pkg::POINTS - 1))
                    state_next = fftr2_pkg::ST_LOAD;
            end
            default: state_next = fftr2_pkg::ST_LOAD;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        busy = (state_reg != fftr2_pkg::ST_LOAD);
        ctrl.mul_en = (state_reg == fftr2_pkg::ST_MUL);
        ctrl.wr_en = (state_reg == fftr2_pkg::ST_WR);
        ctrl.tw_k = AW'((cnt_reg & half_mask) << (AW - 1 - int'(stg_reg)));
        case (state_reg)
            fftr2_pkg::ST_RD_A: rd_addr = ia;
            fftr2_pkg::ST_RD_B: rd_addr = ib;
            default:            rd_addr = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fftr2_pkg::ST_LOAD;
            cnt_reg <= '0;
            stg_reg <= '0;
            src_ping_reg <= 1'b0;
            wr_second_reg <= 1'b0;
            emit_vld_reg <= 1'b0;
            emit_last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            stg_reg <= stg_next;
            src_ping_reg <= src_ping_next;
            wr_second_reg <= ctrl.wr_en && !wr_second_reg;
            emit_vld_reg <= (state_reg == fftr2_pkg::ST_EMIT);
            emit_last_reg <= (state_reg == fftr2_pkg::ST_EMIT) &&
                             (cnt_reg == AW'(fftr2_pkg::POINTS - 1));
        end
    end

    // WR state writes the A result, then the B result
    // (state stays in WR until wr_second_reg is set)

    // Stores: load goes to pong; stages alternate
    always_ff @(posedge clk)
    begin
        if (accept)
            pong_mem[fftr2_pkg::bit_rev(cnt_reg)] <= {{8{sample[15]}}, sample, 24'd0};
        else if (ctrl.wr_en && src_ping_reg)
            pong_mem[wr_second_reg ? ib : ia] <= wr_second_reg ? dif_word : sum_word;
        if (ctrl.wr_en && !src_ping_reg)
            ping_mem[wr_second_reg ? ib : ia] <= wr_second_reg ? dif_word : sum_word;
        rd_reg <= src_ping_reg ? ping_mem[rd_addr] : pong_mem[rd_addr];
    end

    // Operand capture
    always_ff @(posedge clk)
    begin
        if (state_reg == fftr2_pkg::ST_RD_B)
            a_reg <= rd_reg;
    end

    fftr2_bfly u_bfly (
        .clk      (clk),
        .ctrl     (ctrl),
        .a_word   (a_reg),
        .b_word   (rd_reg),
        .sum_word (sum_word),
        .dif_word (dif_word)
    );

    // Output scaling
    assign done = emit_vld_reg;
    assign final_bin = emit_last_reg;
    assign bin_real = fftr2_pkg::scale_out(rd_reg[47:24]);
    assign bin_imag = fftr2_pkg::scale_out(rd_reg[23:0]);

    `CHK_IMPL(a_no_start_busy, clk, rst_n, done, busy || final_bin)
    `CHK_NEXT(a_last_ends, clk, rst_n, final_bin, !done)
    `CHK_IMPL(a_wr_src, clk, rst_n, ctrl.wr_en, busy)
    `CHK_NEXT(a_wr_pair, clk, rst_n, ctrl.wr_en && !wr_second_reg, ctrl.wr_en)
endmodule
